// File: hw/rtl/stochastic_universal_selector_assert.svh
// assertion macros, clocked on clock and disabled during reset
`ifndef STOCHASTIC_UNIVERSAL_SELECTOR_ASSERT_SVH
`define STOCHASTIC_UNIVERSAL_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SUS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SUS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SUS_ASSERT_IMPL(lbl, ante, cons)
`define SUS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/sus_pkg.sv
`default_nettype none
package sus_pkg;
   localparam int unsigned POP        = 64;
   localparam int unsigned IdxW       = $clog2(POP);
   localparam int unsigned CntW       = $clog2(POP + 1);
   localparam int unsigned AddrW      = IdxW + 1;
   localparam int unsigned FitW       = 16;
   localparam int unsigned TotalW     = 22;
   localparam int unsigned FracW      = 17;
   localparam int unsigned FracShift  = 16;
   localparam int unsigned RhsW       = TotalW + CntW + FracShift;
   localparam int unsigned IndexW     = 6;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QPtrW      = $clog2(QueueDepth);
   localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
   localparam logic [FracW-1:0] OneFrac = FracW'(32'd1 << FracShift);

   typedef struct packed {
      logic              bank;
      logic [CntW-1:0]   count;
      logic [TotalW-1:0] total;
      logic [FracW-1:0]  frac;
   } run_type;

   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
      logic [FitW-1:0]  data;
   } store_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;
endpackage
`default_nettype wire

// File: hw/rtl/sus_req_if.sv
`default_nettype none
interface sus_req_if;
   logic                         valid;
   logic                         ready;
   logic [sus_pkg::FitW-1:0]     fitness;
   logic                         last_item;
   logic [sus_pkg::FracW-1:0]    random_fraction;

   modport source (output valid, fitness, last_item, random_fraction, input ready);
   modport sink (input valid, fitness, last_item, random_fraction, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sus_rsp_if.sv
`default_nettype none
interface sus_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sus_pkg::IndexW-1:0]   selected_index;
   logic                         last_index;

   modport source (output valid, selected_index, last_index, input ready);
   modport sink (input valid, selected_index, last_index, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/stochastic_universal_selector.sv
// loading: one fitness word per cycle while the run queue is not full, stored in one of two banks
// selection of a run of N: a cumulative walk over the N stored entries
// (fetch, multiply-accumulate and compare per entry, an index emitted when the output is free)
// a second run loads into the other bank while the first is still emitting
// reset (synchronous, active high) empties the run queue and clears the counters
`default_nettype none
module stochastic_universal_selector (
   input  logic        clock,
   input  logic        reset,
   sus_req_if.sink     req_if,
   sus_rsp_if.source   rsp_if
);
   logic                    push;
   logic                    pop;
   sus_pkg::run_type        push_run;
   sus_pkg::run_type        head;
   sus_pkg::queue_stat_type q_stat;
   sus_pkg::store_wr_type   store_wr;

   sus_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_stat   (q_stat),
      .push     (push),
      .push_run (push_run),
      .store_wr (store_wr)
   );

   sus_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   sus_back u_back (
      .clock    (clock),
      .reset    (reset),
      .store_wr (store_wr),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );
endmodule
`default_nettype wire

// File: hw/rtl/sus_front.sv
`default_nettype none
module sus_front (
   input  logic                  clock,
   input  logic                  reset,
   sus_req_if.sink               req_if,
   input  sus_pkg::queue_stat_type q_stat,
   output logic                  push,
   output sus_pkg::run_type      push_run,
   output sus_pkg::store_wr_type store_wr
);
   logic [sus_pkg::CntW-1:0]   count_ff, count_in;
   logic [sus_pkg::TotalW-1:0] total_ff, total_in;
   logic                       bank_ff, bank_in;
   logic                       accept;
   logic                       store_full;
   logic [sus_pkg::TotalW-1:0] sum;
   logic [sus_pkg::FracW-1:0]  frac_sat;

   assign req_if.ready = !q_stat.full;
   assign accept       = req_if.valid && req_if.ready;
   assign store_full   = (count_ff == sus_pkg::CntW'(sus_pkg::POP));
   assign sum          = total_ff + sus_pkg::TotalW'(req_if.fitness);
   assign frac_sat     = (req_if.random_fraction > sus_pkg::OneFrac) ?
                         sus_pkg::OneFrac : req_if.random_fraction;

   always_comb begin
      count_in       = count_ff;
      total_in       = total_ff;
      bank_in        = bank_ff;
      push           = 1'b0;
      push_run.bank  = bank_ff;
      push_run.count = count_ff;
      push_run.total = total_ff;
      push_run.frac  = frac_sat;
      store_wr.en    = 1'b0;
      store_wr.addr  = {bank_ff, count_ff[sus_pkg::IdxW-1:0]};
      store_wr.data  = req_if.fitness;
      if (accept) begin
         if (store_full) begin
            // store full: word closes the run, its fitness is dropped
            push     = 1'b1;
            count_in = '0;
            total_in = '0;
            bank_in  = !bank_ff;
         end else begin
            store_wr.en = 1'b1;
            if (req_if.last_item) begin
               push           = 1'b1;
               push_run.count = count_ff + sus_pkg::CntW'(1);
               push_run.total = sum;
               count_in       = '0;
               total_in       = '0;
               bank_in        = !bank_ff;
            end else begin
               count_in = count_ff + sus_pkg::CntW'(1);
               total_in = sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         bank_ff  <= bank_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/sus_queue.sv
`default_nettype none
module sus_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sus_pkg::run_type        push_run,
   input  logic                    pop,
   output sus_pkg::run_type        head,
   output sus_pkg::queue_stat_type q_stat
);
   sus_pkg::run_type            entries [sus_pkg::QueueDepth];
   logic [sus_pkg::QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sus_pkg::QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sus_pkg::QCntW-1:0]   cnt_ff, cnt_in;
   logic                        do_push;
   logic                        do_pop;

   assign q_stat.full  = (cnt_ff == sus_pkg::QCntW'(sus_pkg::QueueDepth));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sus_pkg::QPtrW'(sus_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + sus_pkg::QPtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sus_pkg::QPtrW'(sus_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + sus_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + sus_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - sus_pkg::QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/sus_back.sv
`default_nettype none
`include "stochastic_universal_selector_assert.svh"
module sus_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sus_pkg::store_wr_type   store_wr,
   input  sus_pkg::run_type        head,
   input  sus_pkg::queue_stat_type q_stat,
   output logic                    pop,
   sus_rsp_if.source               rsp_if
);
   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StInit  = 2'd1;
   localparam logic [1:0] StCheck = 2'd2;
   localparam logic [1:0] StAcc   = 2'd3;

   logic [sus_pkg::FitW-1:0]   store_mem [2 * sus_pkg::POP];
   logic [sus_pkg::FitW-1:0]   rd_data_ff;
   logic                       rd_en;
   logic [sus_pkg::AddrW-1:0]  rd_addr;

   logic [1:0]                 state_ff, state_in;
   logic                       bank_ff, bank_in;
   logic [sus_pkg::CntW-1:0]   n_ff, n_in;
   logic [sus_pkg::TotalW-1:0] total_ff, total_in;
   logic [sus_pkg::FracW-1:0]  frac_ff, frac_in;
   logic [sus_pkg::RhsW-1:0]   rhs_ff, rhs_in;
   logic [sus_pkg::RhsW-1:0]   lhs_ff, lhs_in;
   logic [sus_pkg::CntW-1:0]   k_ff, k_in;
   logic [sus_pkg::CntW-1:0]   i_ff, i_in;
   logic                       have_ff, have_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [sus_pkg::IndexW-1:0] rsp_index_ff, rsp_index_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [sus_pkg::TotalW+sus_pkg::FracW-1:0] init_prod;
   logic [sus_pkg::FitW+sus_pkg::CntW-1:0]    step_prod;
   logic                       out_free;
   logic                       emit;
   logic                       emit_last;
   logic [sus_pkg::IdxW-1:0]   emit_sel;

   assign init_prod = total_ff * frac_ff;
   assign step_prod = rd_data_ff * n_ff;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign emit_last = (i_ff == n_ff - sus_pkg::CntW'(1));

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.selected_index = rsp_index_ff;
   assign rsp_if.last_index     = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      n_in         = n_ff;
      total_in     = total_ff;
      frac_in      = frac_ff;
      rhs_in       = rhs_ff;
      lhs_in       = lhs_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      rd_addr      = {bank_ff, k_ff[sus_pkg::IdxW-1:0]};
      pop          = 1'b0;
      emit         = 1'b0;
      emit_sel     = '0;
      case (state_ff)
         StIdle: begin
            if (!q_stat.empty) begin
               bank_in  = head.bank;
               n_in     = head.count;
               total_in = head.total;
               frac_in  = head.frac;
               lhs_in   = '0;
               k_in     = '0;
               i_in     = '0;
               have_in  = 1'b0;
               state_in = StInit;
            end
         end
         StInit: begin
            rhs_in   = sus_pkg::RhsW'(init_prod);
            state_in = StCheck;
         end
         StCheck: begin
            if (!have_ff) begin
               if (k_ff == n_ff) begin
                  // every entry passed: pointer lands on index zero
                  emit = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  state_in = StAcc;
               end
            end else if (lhs_ff > rhs_ff) begin
               emit     = 1'b1;
               emit_sel = k_ff[sus_pkg::IdxW-1:0];
            end else begin
               k_in    = k_ff + sus_pkg::CntW'(1);
               have_in = 1'b0;
            end
            if (emit && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = sus_pkg::IndexW'(emit_sel);
               rsp_last_in  = emit_last;
               i_in         = i_ff + sus_pkg::CntW'(1);
               rhs_in       = rhs_ff + (sus_pkg::RhsW'(total_ff) << sus_pkg::FracShift);
               if (emit_last) begin
                  pop      = 1'b1;
                  state_in = StIdle;
               end
            end
         end
         StAcc: begin
            lhs_in   = lhs_ff + (sus_pkg::RhsW'(step_prod) << sus_pkg::FracShift);
            have_in  = 1'b1;
            state_in = StCheck;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bank_ff      <= bank_in;
      n_ff         <= n_in;
      total_ff     <= total_in;
      frac_ff      <= frac_in;
      rhs_ff       <= rhs_in;
      lhs_ff       <= lhs_in;
      k_ff         <= k_in;
      i_ff         <= i_in;
      have_ff      <= have_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SUS_ASSERT_IMPL(a_k_in_range, state_ff != StIdle, k_ff <= n_ff)
   `SUS_ASSERT_IMPL(a_i_in_range, state_ff != StIdle, i_ff < n_ff)
   `SUS_ASSERT_NEXT(a_done_idle, pop, state_ff == StIdle && rsp_valid_ff && rsp_last_ff)
endmodule
`default_nettype wire

// File: tb/sv/tb_stochastic_universal_selector.sv
`timescale 1ns / 100ps

module tb_stochastic_universal_selector;

   localparam int unsigned StallLimit = 3000;
   localparam int unsigned DrainCycles = 320;
   localparam int unsigned RandomWords = 270;
   localparam longint unsigned FracOne = 65536;
   localparam logic [sus_pkg::FitW-1:0] FitMax = '1;

   typedef struct {
      logic [sus_pkg::FitW-1:0]  fitness;
      logic                      last_item;
      logic [sus_pkg::FracW-1:0] frac;
      bit                        drain_first;
   } fit_word_type;

   typedef struct {
      logic [sus_pkg::IndexW-1:0] index;
      logic                       last;
   } survivor_type;

   logic clock;
   logic reset;

   sus_req_if req_bus ();
   sus_rsp_if rsp_bus ();

   stochastic_universal_selector dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   fit_word_type   fit_words[$];
   survivor_type   survivors[$];
   fit_word_type   next_word;

   logic [sus_pkg::FitW-1:0]   pool_fit[sus_pkg::POP];
   logic [sus_pkg::TotalW-1:0] pool_sum;
   int unsigned                pool_count;

   logic        req_taken;
   int unsigned stall_cycles;
   int unsigned send_wait;
   int unsigned rsp_wait;
   bit          send_calm;
   bit          rsp_calm;
   int unsigned errors;
   int unsigned words_in;
   int unsigned results_seen;
   int unsigned runs_done;
   int unsigned full_runs;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [sus_pkg::FitW-1:0] rand_fitness();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FitMax;
         2: return sus_pkg::FitW'($urandom_range(0, 255));
         default: return sus_pkg::FitW'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [sus_pkg::FracW-1:0] rand_frac();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return sus_pkg::OneFrac;
         2: return sus_pkg::FracW'($urandom_range(65537, 131071));
         default: return sus_pkg::FracW'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic add_word(input logic [sus_pkg::FitW-1:0] fit, input logic last,
                           input logic [sus_pkg::FracW-1:0] frac, input bit drain);
      fit_word_type w;
      w.fitness = fit;
      w.last_item = last;
      w.frac = frac;
      w.drain_first = drain;
      fit_words.insert(fit_words.size(), w);
   endtask

   // size words, the final one marked last unless the store is to overflow
   task automatic add_run(input int unsigned size, input bit overflow, input bit drain);
      for (int unsigned j = 0; j < size; j++)
         add_word(rand_fitness(), (j == size - 1) && !overflow, rand_frac(), drain && j == 0);
      if (overflow)
         add_word(rand_fitness(), 1'($urandom_range(0, 1)), rand_frac(), 1'b0);
   endtask

   task automatic select_survivors(input logic [sus_pkg::FracW-1:0] frac);
      int unsigned n;
      int unsigned k;
      longint unsigned r;
      longint unsigned rhs;
      longint unsigned cum;
      bit have_k;
      survivor_type s;
      n = pool_count;
      r = frac;
      if (r > FracOne) r = FracOne;
      cum = 0;
      k = 0;
      have_k = 0;
      for (int unsigned i = 0; i < n; i++) begin
         rhs = longint'(pool_sum) * (r + longint'(i) * FracOne);
         while (1) begin
            if (!have_k) begin
               if (k >= n) break;
               cum += pool_fit[k];
               have_k = 1;
            end
            if (cum * longint'(n) * FracOne > rhs) break;
            k++;
            have_k = 0;
         end
         s.index = (k < n) ? sus_pkg::IndexW'(k) : '0;
         s.last = (i + 1 == n);
         survivors.insert(survivors.size(), s);
      end
      pool_sum = '0;
      pool_count = 0;
      runs_done++;
   endtask

   task automatic load_fitness(input logic [sus_pkg::FitW-1:0] fit, input logic last,
                               input logic [sus_pkg::FracW-1:0] frac);
      if (pool_count >= sus_pkg::POP) begin
         full_runs++;
         select_survivors(frac);
      end else begin
         pool_fit[pool_count] = fit;
         pool_sum = pool_sum + sus_pkg::TotalW'(fit);
         pool_count++;
         if (last) select_survivors(frac);
      end
   endtask

   task automatic check_survivor(input logic [sus_pkg::IndexW-1:0] index, input logic last);
      survivor_type s;
      results_seen++;
      if (survivors.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%t unexpected survivor index %0d last %0b", $realtime, index, last);
      end else begin
         s = survivors.pop_front();
         if (index !== s.index || last !== s.last) begin
            errors++;
            if (errors <= 10)
               $display("%t mismatch: expected index %0d last %0b, got index %0d last %0b",
                        $realtime, s.index, s.last, index, last);
         end
      end
   endtask

   // monitor and predictor, sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            words_in++;
            load_fitness(req_bus.fitness, req_bus.last_item, req_bus.random_fraction);
         end
         if (rsp_bus.valid && rsp_bus.ready)
            check_survivor(rsp_bus.selected_index, rsp_bus.last_index);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
         else if (fit_words.size() > 0 || req_bus.valid || survivors.size() > 0)
            stall_cycles <= stall_cycles + 1;
         else
            stall_cycles <= 0;
      end
   end

   // driver, inputs change at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (send_wait > 0) begin
               send_wait--;
               req_bus.valid <= 1'b0;
            end else if (fit_words.size() > 0 &&
                         !(fit_words[0].drain_first && survivors.size() > 0)) begin
               next_word = fit_words.pop_front();
               req_bus.fitness <= next_word.fitness;
               req_bus.last_item <= next_word.last_item;
               req_bus.random_fraction <= next_word.frac;
               req_bus.valid <= 1'b1;
               send_wait = send_calm ? 0 : pick_gap();
               if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 2) == 0) rsp_wait = pick_gap();
         end
         if ($urandom_range(0, 149) == 0) rsp_calm = !rsp_calm;
      end
   end

   initial begin
      int unsigned run_no;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.fitness = '0;
      req_bus.last_item = 1'b0;
      req_bus.random_fraction = '0;
      rsp_bus.ready = 1'b0;
      pool_sum = '0;
      pool_count = 0;
      send_wait = 0;
      rsp_wait = 0;
      send_calm = 1'b0;
      rsp_calm = 1'b0;
      errors = 0;
      words_in = 0;
      results_seen = 0;
      runs_done = 0;
      full_runs = 0;

      // single entries: max fitness with r = 0, zero fitness with r = 1
      add_word(FitMax, 1'b1, '0, 1'b0);
      add_word('0, 1'b1, sus_pkg::OneFrac, 1'b0);
      // zero sum
      add_word('0, 1'b0, '0, 1'b0);
      add_word('0, 1'b0, '1, 1'b0);
      add_word('0, 1'b1, 17'd12345, 1'b0);
      // r = 1, final pointer past every entry
      add_word(FitMax, 1'b0, '0, 1'b0);
      add_word(FitMax, 1'b1, sus_pkg::OneFrac, 1'b0);
      // fraction above range saturates
      add_word(16'h0001, 1'b0, '0, 1'b0);
      add_word(16'h8000, 1'b0, '0, 1'b0);
      add_word(FitMax, 1'b1, '1, 1'b0);
      // one nonzero entry among zeros
      add_word('0, 1'b0, '0, 1'b0);
      add_word('0, 1'b0, '0, 1'b0);
      add_word(16'h0100, 1'b0, '0, 1'b0);
      add_word('0, 1'b1, 17'd65535, 1'b0);
      add_word(FitMax, 1'b0, '0, 1'b0);
      add_word('0, 1'b0, '0, 1'b0);
      add_word('0, 1'b1, 17'h10001, 1'b0);
      add_word(16'h00ff, 1'b0, '0, 1'b0);
      add_word(16'h0001, 1'b1, 17'd1, 1'b0);

      run_no = 0;
      while (fit_words.size() < RandomWords) begin
         if (run_no == 2)
            add_run(sus_pkg::POP, 1'b1, 1'b0);
         else if (run_no == 6)
            add_run(sus_pkg::POP, 1'b0, 1'b0);
         else if ($urandom_range(0, 39) == 0)
            add_run($urandom_range(11, sus_pkg::POP), 1'b0, 1'b0);
         else
            add_run($urandom_range(1, 10), 1'b0, run_no % 10 == 0);
         run_no++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while ((fit_words.size() > 0 || req_bus.valid || survivors.size() > 0) &&
             stall_cycles < StallLimit)
         @(posedge clock);
      if (stall_cycles >= StallLimit) begin
         $display("timeout: %0d words pending, %0d survivor indices outstanding",
                  fit_words.size(), survivors.size());
         $display("tb_stochastic_universal_selector: errors");
         $finish;
      end else begin
         repeat (DrainCycles) @(posedge clock);
         errors += survivors.size();
         $display("%0d fitness words in %0d selection runs, %0d of them past a full store",
                  words_in, runs_done, full_runs);
         $display("%0d survivor indices checked, %0d errors", results_seen, errors);
         if (errors == 0)
            $display("tb_stochastic_universal_selector: clean");
         else
            $display("tb_stochastic_universal_selector: errors");
         $finish;
      end
   end

endmodule
